### sv/ttceb_pkg.sv
// shared types, constants and the sine table function for the ttc emergency brake
package ttceb_pkg;

    // field widths
    localparam int SPEED_W = 16;
    localparam int RANGE_W = 16;
    localparam int TTC_W   = 16;
    localparam int THR_W   = 18;
    localparam int TRIG_W  = 16;
    localparam int RATE_W  = 30;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    // shared multiplier operand and product widths
    localparam int MUL_A_W = 37;
    localparam int MUL_B_W = 23;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_ANGLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_GAIN  = 2'd3;

    // configuration reset values
    localparam logic signed [15:0] START_ANGLE_RST = -16'sd9651;
    localparam logic [11:0] ANGLE_STEP_RST = 12'd18;
    localparam logic [11:0] HALF_WIDTH_RST = 12'd203;
    localparam logic [11:0] BRAKE_GAIN_RST = 12'd640;

    // no threat marker
    localparam logic [TTC_W-1:0] NO_TTC = 16'hFFFF;

    // angle constants in Q28, and 1/(2*pi) in Q24
    localparam longint TWO_PI_Q28  = 64'sd1686629713;
    localparam longint PI_Q28      = 64'sd843314857;
    localparam longint HALF_PI_Q28 = 64'sd421657428;
    localparam logic [21:0] INV_TWO_PI_Q24 = 22'd2670177;

    // divider status seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } ttceb_div_stat_t;

    // sine in Q14 of an angle in Q28, 0 <= a < 2.5*pi, odd series through x^11
    function automatic logic signed [TRIG_W-1:0] sine_q14(input longint a_in);
        longint a;
        longint x;
        longint x2;
        longint t;
        longint s;
        logic   neg;
        a   = a_in;
        neg = 1'b0;
        if (a >= TWO_PI_Q28) begin
            a = a - TWO_PI_Q28;
        end
        if (a >= PI_Q28) begin
            a   = a - PI_Q28;
            neg = 1'b1;
        end
        if (a > HALF_PI_Q28) begin
            a = PI_Q28 - a;
        end
        x  = a;
        x2 = (x * x) >>> 28;
        t  = x;
        s  = x;
        t  = ((t * x2) >>> 28) / 6;
        s  = s - t;
        t  = ((t * x2) >>> 28) / 20;
        s  = s + t;
        t  = ((t * x2) >>> 28) / 42;
        s  = s - t;
        t  = ((t * x2) >>> 28) / 72;
        s  = s + t;
        t  = ((t * x2) >>> 28) / 110;
        s  = s - t;
        if (s < 0) begin
            s = 0;
        end
        s = (s + 64'sd8192) >>> 14;
        return neg ? TRIG_W'(-s) : TRIG_W'(s);
    endfunction

endpackage

### sv/ttceb_trig_rom.sv
// sine and cosine rom over one full turn, q1.14, registered read
module ttceb_trig_rom
    import ttceb_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic                           aclk,
    input  logic [$clog2(DEPTH)-1:0]       addr,
    output logic signed [TRIG_W-1:0]       sin_reg,
    output logic signed [TRIG_W-1:0]       cos_reg
);

    logic signed [TRIG_W-1:0] sin_tab [DEPTH];
    logic signed [TRIG_W-1:0] cos_tab [DEPTH];

    // table contents, fixed at elaboration
    for (genvar k = 0; k < DEPTH; k++) begin : g_entry
        localparam longint ANGLE = (TWO_PI_Q28 * longint'(k)) / DEPTH;
        localparam logic signed [TRIG_W-1:0] SIN_K = sine_q14(ANGLE);
        localparam logic signed [TRIG_W-1:0] COS_K = sine_q14(ANGLE + HALF_PI_Q28);
        assign sin_tab[k] = SIN_K;
        assign cos_tab[k] = COS_K;
    end

    // registered read port
    always_ff @(posedge aclk) begin
        sin_reg <= sin_tab[addr];
        cos_reg <= cos_tab[addr];
    end

endmodule

### sv/ttceb_div.sv
// serial divider for time to collision: range*1000*2^14 / rate, saturated to 16 bits
module ttceb_div
    import ttceb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [RANGE_W-1:0]   range_mm,
    input  logic [RATE_W-1:0]    rate,
    output ttceb_div_stat_t      stat,
    output logic [TTC_W-1:0]     quot_reg
);

    localparam int NUM_W = RANGE_W + 10 + 14;
    localparam int DSH_W = RATE_W + TTC_W;
    localparam int CNT_W = $clog2(TTC_W);

    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_CHK  = 2'd1;
    localparam logic [1:0] D_RUN  = 2'd2;

    logic [1:0]          state_reg;
    logic [1:0]          state_next;
    logic [NUM_W-1:0]    rem_reg;
    logic [RATE_W-1:0]   den_reg;
    logic [DSH_W-1:0]    dsh_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [RANGE_W+9:0]  r1000;
    logic                ovf;
    logic                fits;
    logic [DSH_W-1:0]    rem_ext;

    // range times 1000 by shift and subtract
    assign r1000 = {range_mm, 10'b0} - {6'b0, range_mm, 4'b0} - {7'b0, range_mm, 3'b0};

    // quotient would not fit in 16 bits
    assign rem_ext = {{(DSH_W-NUM_W){1'b0}}, rem_reg};
    assign ovf     = rem_ext >= {den_reg, {TTC_W{1'b0}}};
    assign fits    = rem_ext >= dsh_reg;

    assign stat.busy = (state_reg != D_IDLE);
    assign stat.done = ((state_reg == D_CHK) && ovf) ||
                       ((state_reg == D_RUN) && (cnt_reg == '0));

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            D_IDLE: begin
                if (start) begin
                    state_next = D_CHK;
                end
            end
            D_CHK: begin
                state_next = ovf ? D_IDLE : D_RUN;
            end
            D_RUN: begin
                if (cnt_reg == '0) begin
                    state_next = D_IDLE;
                end
            end
            default: begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // restoring division, one quotient bit per cycle
    always_ff @(posedge aclk) begin
        case (state_reg)
            D_IDLE: begin
                if (start) begin
                    rem_reg <= {r1000, 14'b0};
                    den_reg <= rate;
                end
            end
            D_CHK: begin
                dsh_reg <= {1'b0, den_reg, {(TTC_W-1){1'b0}}};
                cnt_reg <= CNT_W'(TTC_W - 1);
                if (ovf) begin
                    quot_reg <= NO_TTC;
                end
            end
            D_RUN: begin
                if (fits) begin
                    rem_reg  <= NUM_W'(rem_ext - dsh_reg);
                    quot_reg <= {quot_reg[TTC_W-2:0], 1'b1};
                end else begin
                    quot_reg <= {quot_reg[TTC_W-2:0], 1'b0};
                end
                dsh_reg <= dsh_reg >> 1;
                cnt_reg <= cnt_reg - 1'b1;
            end
            default: begin
            end
        endcase
    end

endmodule

### sv/ttc_emergency_brake.sv
// top level of the time to collision emergency brake
//
// A speed update (tuser 0) is captured on its transfer without leaving idle. A beam sample
// (tuser 1) runs through a small sequencer around one shared signed 37x23 multiplier: beam
// angle, turn fraction, rom index, rom read, lateral offset, closing rate and braking
// threshold. A beam with a valid range, inside the corridor and with a positive closing
// rate also goes through the serial divider, one quotient bit per cycle. While a beam is in
// work s_tready is low. The last beam of a scan loads the result register; the block takes
// further transfers while that result waits, and only holds a following last beam until the
// previous result is gone. Registers are written through cfg_we, cfg_index (0 start angle,
// 1 angle step, 2 half width, 3 brake gain) and cfg_data; the user must write them only
// while idle, the block itself does not enforce it.
module ttc_emergency_brake
    import ttceb_pkg::*;
#(
    parameter int MAX_BEAMS        = 2048,
    parameter int TRIG_TABLE_DEPTH = 1024
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input channel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [39:0]           s_tdata,   // speed_mm_s, range_mm, range_valid, zero pad
    input  logic                  s_tuser,   // cmd
    input  logic                  s_tlast,   // last_beam
    // result channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [39:0]           m_tdata,   // brake, min_ttc_ms, threshold_ms, zero pad
    // configuration writes
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    localparam int BI_W    = $clog2(MAX_BEAMS);
    localparam int IDX_W   = $clog2(TRIG_TABLE_DEPTH);
    localparam int THETA_W = BI_W + 14;
    localparam logic [BI_W-1:0] BI_LAST = BI_W'(MAX_BEAMS - 1);
    localparam logic [IDX_W:0]  IDX_WRAP = (IDX_W+1)'(TRIG_TABLE_DEPTH);
    localparam logic signed [THR_W-1:0] THR_MAX = 18'sd131071;
    localparam logic signed [THR_W-1:0] THR_MIN = -18'sd131072;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_THETA  = 4'd1;
    localparam logic [3:0] S_TURN   = 4'd2;
    localparam logic [3:0] S_IDX    = 4'd3;
    localparam logic [3:0] S_ROM    = 4'd4;
    localparam logic [3:0] S_LAT    = 4'd5;
    localparam logic [3:0] S_RATE   = 4'd6;
    localparam logic [3:0] S_DECIDE = 4'd7;
    localparam logic [3:0] S_DIV    = 4'd8;
    localparam logic [3:0] S_FIN    = 4'd9;

    // configuration
    logic signed [15:0]         start_angle_reg;
    logic [11:0]                angle_step_reg;
    logic [11:0]                half_width_reg;
    logic [11:0]                brake_gain_reg;

    // scan state
    logic signed [SPEED_W-1:0]  speed_reg;
    logic [BI_W-1:0]            beam_index_reg;
    logic [TTC_W-1:0]           min_ttc_reg;
    logic                       threat_reg;

    // item in work
    logic [3:0]                 state_reg;
    logic [3:0]                 state_next;
    logic [RANGE_W-1:0]         range_reg;
    logic                       valid_reg;
    logic                       last_reg;
    logic                       lat_ok_reg;
    logic                       took_reg;
    logic [MUL_P_W-1:0]         prod_reg;

    // result register
    logic                       m_tvalid_reg;
    logic [39:0]                m_tdata_reg;

    // datapath nets
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [MUL_P_W-1:0]  prod_next;
    logic                       mul_en;
    logic signed [THETA_W-1:0]  theta;
    logic [IDX_W+1:0]           idx_half;
    logic [IDX_W:0]             idx_round;
    logic [IDX_W-1:0]           rom_addr;
    logic signed [TRIG_W-1:0]   sin_reg;
    logic signed [TRIG_W-1:0]   cos_reg;
    logic [TRIG_W-1:0]          abs_sin;
    logic                       rate_pos;
    logic                       take;
    logic                       s_xfer;
    logic                       fin_go;
    logic                       div_start;
    ttceb_div_stat_t            div_stat;
    logic [TTC_W-1:0]           div_quot;
    logic [TTC_W-1:0]           min_new;
    logic                       threat_new;
    logic signed [MUL_P_W-9:0]  thr_full;
    logic signed [THR_W-1:0]    thr_sat;
    logic                       brake;

    assign s_tready = (state_reg == S_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_angle_reg <= START_ANGLE_RST;
            angle_step_reg  <= ANGLE_STEP_RST;
            half_width_reg  <= HALF_WIDTH_RST;
            brake_gain_reg  <= BRAKE_GAIN_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_START_ANGLE: start_angle_reg <= $signed(cfg_data);
                CFG_ANGLE_STEP:  angle_step_reg  <= cfg_data[11:0];
                CFG_HALF_WIDTH:  half_width_reg  <= cfg_data[11:0];
                CFG_BRAKE_GAIN:  brake_gain_reg  <= cfg_data[11:0];
                default: begin
                end
            endcase
        end
    end

    // beam angle, and rom index rounded from the turn fraction
    assign theta = $signed({{(THETA_W-16){start_angle_reg[15]}}, start_angle_reg}) +
                   $signed({2'b0, prod_reg[BI_W+11:0]});
    assign idx_half  = prod_reg[IDX_W+36:35];
    assign idx_round = (IDX_W+1)'((idx_half + 1'b1) >> 1);
    assign rom_addr  = (idx_round == IDX_WRAP) ? '0 : idx_round[IDX_W-1:0];
    assign abs_sin   = sin_reg[TRIG_W-1] ? TRIG_W'(-sin_reg) : sin_reg;

    ttceb_trig_rom #(
        .DEPTH (TRIG_TABLE_DEPTH)
    ) u_rom (
        .aclk    (aclk),
        .addr    (rom_addr),
        .sin_reg (sin_reg),
        .cos_reg (cos_reg)
    );

    // shared multiplier operand select
    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        case (state_reg)
            S_THETA: begin
                mul_a = $signed({{(MUL_A_W-BI_W){1'b0}}, beam_index_reg});
                mul_b = $signed({{(MUL_B_W-12){1'b0}}, angle_step_reg});
            end
            S_TURN: begin
                mul_a = {{(MUL_A_W-THETA_W){theta[THETA_W-1]}}, theta};
                mul_b = $signed({{(MUL_B_W-22){1'b0}}, INV_TWO_PI_Q24});
            end
            S_IDX: begin
                mul_a = $signed({1'b0, prod_reg[35:0]});
                mul_b = $signed(MUL_B_W'(TRIG_TABLE_DEPTH));
            end
            S_LAT: begin
                mul_a = $signed({{(MUL_A_W-TRIG_W){1'b0}}, abs_sin});
                mul_b = $signed({{(MUL_B_W-RANGE_W){1'b0}}, range_reg});
            end
            S_RATE: begin
                mul_a = {{(MUL_A_W-SPEED_W){speed_reg[SPEED_W-1]}}, speed_reg};
                mul_b = {{(MUL_B_W-TRIG_W){cos_reg[TRIG_W-1]}}, cos_reg};
            end
            S_DECIDE: begin
                mul_a = {{(MUL_A_W-SPEED_W){speed_reg[SPEED_W-1]}}, speed_reg};
                mul_b = $signed({{(MUL_B_W-12){1'b0}}, brake_gain_reg});
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg <= prod_next;
        end
    end

    // corridor test, closing rate check and divider launch
    always_ff @(posedge aclk) begin
        if (state_reg == S_RATE) begin
            lat_ok_reg <= prod_reg < MUL_P_W'({half_width_reg, 14'b0});
        end
        if (state_reg == S_DECIDE) begin
            took_reg <= take;
        end
    end

    assign rate_pos  = !prod_reg[MUL_P_W-1] && (prod_reg != '0);
    assign take      = valid_reg && lat_ok_reg && rate_pos;
    assign div_start = (state_reg == S_DECIDE) && take;

    ttceb_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .range_mm (range_reg),
        .rate     (prod_reg[RATE_W-1:0]),
        .stat     (div_stat),
        .quot_reg (div_quot)
    );

    // scan bookkeeping and threshold
    assign threat_new = threat_reg || took_reg;
    assign min_new    = (took_reg && (div_quot < min_ttc_reg)) ? div_quot : min_ttc_reg;
    assign thr_full   = $signed(prod_reg[MUL_P_W-1:8]);
    always_comb begin
        if (thr_full > (MUL_P_W-8)'(THR_MAX)) begin
            thr_sat = THR_MAX;
        end else if (thr_full < (MUL_P_W-8)'(THR_MIN)) begin
            thr_sat = THR_MIN;
        end else begin
            thr_sat = thr_full[THR_W-1:0];
        end
    end
    assign brake  = threat_new && ($signed({2'b0, min_new}) <= thr_sat);
    assign fin_go = (state_reg == S_FIN) && (!last_reg || !m_tvalid_reg || m_tready);

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_xfer && s_tuser) begin
                    state_next = S_THETA;
                end
            end
            S_THETA:  state_next = S_TURN;
            S_TURN:   state_next = S_IDX;
            S_IDX:    state_next = S_ROM;
            S_ROM:    state_next = S_LAT;
            S_LAT:    state_next = S_RATE;
            S_RATE:   state_next = S_DECIDE;
            S_DECIDE: state_next = take ? S_DIV : S_FIN;
            S_DIV: begin
                if (div_stat.done) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (fin_go) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // input transfer capture
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            range_reg <= s_tdata[31:16];
            valid_reg <= s_tdata[32];
            last_reg  <= s_tlast;
        end
    end

    // speed and per scan state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_reg      <= '0;
            beam_index_reg <= '0;
            min_ttc_reg    <= NO_TTC;
            threat_reg     <= 1'b0;
        end else begin
            if (s_xfer && !s_tuser) begin
                speed_reg <= $signed(s_tdata[15:0]);
            end
            if (fin_go) begin
                if (last_reg) begin
                    beam_index_reg <= '0;
                    min_ttc_reg    <= NO_TTC;
                    threat_reg     <= 1'b0;
                end else begin
                    if (beam_index_reg != BI_LAST) begin
                        beam_index_reg <= beam_index_reg + 1'b1;
                    end
                    min_ttc_reg <= min_new;
                    threat_reg  <= threat_new;
                end
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (fin_go && last_reg) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fin_go && last_reg) begin
            m_tdata_reg <= {5'b0, thr_sat, (threat_new ? min_new : NO_TTC), brake};
        end
    end

    // checks
    a_ready_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !div_stat.busy)
        else $error("input ready while the divider is busy");

    a_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> (state_reg == S_DIV))
        else $error("divider finished outside the divide wait");

    a_scan_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (fin_go && last_reg) |=> (beam_index_reg == '0) && (min_ttc_reg == NO_TTC) &&
                                 !threat_reg && m_tvalid_reg)
        else $error("scan state not cleared after the last beam");

endmodule
